[src/assert_macros.svh]
// Assertion helpers for the collision block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AST_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define AST_CHK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/d2q9_pkg.sv]
package d2q9_pkg;

  localparam int POP_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF = 28;
  localparam int OMEGA_FRAC    = 28;
  localparam int RELAX_W       = 30;
  localparam logic [RELAX_W-1:0] RELAX_RST = 30'h1000_0000;

  // Intermediate values saturate to +/-2^60.
  localparam int VAL_W = 62;
  localparam logic signed [63:0] LIM = 64'sh1000_0000_0000_0000;

  localparam int NUM_DIR  = 9;
  localparam int MUL_LAT  = 4;
  localparam int LANE_LAT = 5 + 4 * MUL_LAT;

  typedef logic signed [VAL_W-1:0] val_t;

  function automatic val_t sat_val(input logic signed [63:0] v);
    val_t r;
    if (v > LIM) begin
      r = VAL_W'(LIM);
    end else if (v < -LIM) begin
      r = VAL_W'(-LIM);
    end else begin
      r = VAL_W'(v);
    end
    return r;
  endfunction

  function automatic logic signed [1:0] dir_x(input int i);
    logic signed [1:0] r;
    case (i)
      1, 5, 8: r = 2'sd1;
      3, 6, 7: r = -2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] dir_y(input int i);
    logic signed [1:0] r;
    case (i)
      2, 5, 6: r = 2'sd1;
      4, 7, 8: r = -2'sd1;
      default: r = 2'sd0;
    endcase
    return r;
  endfunction

  // Round-to-nearest weights 4/9, 1/9, 1/36 at frac fraction bits.
  function automatic val_t weight(input int i, input int frac);
    logic [63:0] r;
    if (i == 0) begin
      r = ((64'd8 << frac) + 64'd9) / 64'd18;
    end else if (i < 5) begin
      r = ((64'd2 << frac) + 64'd9) / 64'd18;
    end else begin
      r = ((64'd2 << frac) + 64'd36) / 64'd72;
    end
    return VAL_W'(r);
  endfunction

  function automatic val_t c_one(input int frac);
    return VAL_W'(64'd1 << frac);
  endfunction

  function automatic val_t c_three(input int frac);
    return VAL_W'(64'd3 << frac);
  endfunction

  function automatic val_t c_four_half(input int frac);
    return VAL_W'(64'd9 << (frac - 1));
  endfunction

  function automatic val_t c_one_half(input int frac);
    return VAL_W'(64'd3 << (frac - 1));
  endfunction

endpackage

[src/d2q9_mul.sv]
module d2q9_mul #(
  parameter int SH = d2q9_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  d2q9_pkg::val_t    a_i,
  input  d2q9_pkg::val_t    b_i,
  output d2q9_pkg::val_t    p_o
);

  localparam int VW = d2q9_pkg::VAL_W;

  logic [63:0]  ma_q, mb_q;
  logic         neg1_q, neg2_q, neg3_q;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic [127:0] prod_q;
  d2q9_pkg::val_t p_q;

  logic [127:0] prod_d;
  logic [127:0] shr;
  logic [VW-1:0] mag;
  d2q9_pkg::val_t p_d;

  always_comb begin
    prod_d = {64'd0, ll_q} + ({64'd0, lh_q} << 32) + ({64'd0, hl_q} << 32)
           + ({64'd0, hh_q} << 64) + (128'd1 << (SH - 1));
    shr = prod_q >> SH;
    if (shr > 128'(d2q9_pkg::LIM)) begin
      mag = VW'(d2q9_pkg::LIM);
    end else begin
      mag = shr[VW-1:0];
    end
    p_d = neg3_q ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= a_i[VW-1] ? 64'(-a_i) : 64'(a_i);
      mb_q   <= b_i[VW-1] ? 64'(-b_i) : 64'(b_i);
      neg1_q <= a_i[VW-1] ^ b_i[VW-1];
      ll_q   <= ma_q[31:0] * mb_q[31:0];
      lh_q   <= ma_q[31:0] * mb_q[63:32];
      hl_q   <= ma_q[63:32] * mb_q[31:0];
      hh_q   <= ma_q[63:32] * mb_q[63:32];
      neg2_q <= neg1_q;
      prod_q <= prod_d;
      neg3_q <= neg2_q;
      p_q    <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[src/d2q9_div.sv]
module d2q9_div #(
  parameter int POP_BITS  = d2q9_pkg::POP_BITS_DEF,
  parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [POP_BITS+2:0] num_i,
  input  logic signed [POP_BITS+3:0] den_i,
  output d2q9_pkg::val_t             quo_o
);

  localparam int VW = d2q9_pkg::VAL_W;
  localparam int MW = POP_BITS + 2;
  localparam int NW = MW + FRAC_BITS;
  localparam int DW = POP_BITS + 3;
  localparam int QX = (NW > 64) ? NW : 64;

  logic [DW-1:0] r_q [NW];
  logic [NW-1:0] q_q [NW];
  logic [NW-1:0] n_q [NW];
  logic [DW-1:0] d_q [NW];
  logic          neg_q [NW];

  logic [DW-1:0] r_d [NW];
  logic [NW-1:0] q_d [NW];
  logic [NW-1:0] n_d [NW];
  logic [DW-1:0] d_d [NW];
  logic          neg_d [NW];

  logic [MW-1:0] mag0;
  logic [DW-1:0] r_in, d_in;
  logic [NW-1:0] q_in, n_in;
  logic          neg_in;
  logic [DW:0]   trial;
  logic [QX-1:0] qx;
  logic [VW-1:0] qmag;
  d2q9_pkg::val_t quo_q;

  always_comb begin
    mag0 = num_i[POP_BITS+2] ? MW'(-num_i) : MW'(num_i);
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        r_in   = '0;
        q_in   = '0;
        n_in   = NW'(mag0) << FRAC_BITS;
        d_in   = den_i[DW-1:0];
        neg_in = num_i[POP_BITS+2];
      end else begin
        r_in   = r_q[s-1];
        q_in   = q_q[s-1];
        n_in   = n_q[s-1];
        d_in   = d_q[s-1];
        neg_in = neg_q[s-1];
      end
      trial = {r_in, n_in[NW-1]};
      if (trial >= {1'b0, d_in}) begin
        r_d[s] = DW'(trial - {1'b0, d_in});
        q_d[s] = {q_in[NW-2:0], 1'b1};
      end else begin
        r_d[s] = trial[DW-1:0];
        q_d[s] = {q_in[NW-2:0], 1'b0};
      end
      n_d[s]   = n_in << 1;
      d_d[s]   = d_in;
      neg_d[s] = neg_in;
    end
    qx = QX'(q_q[NW-1]);
    if (qx > QX'(d2q9_pkg::LIM)) begin
      qmag = VW'(d2q9_pkg::LIM);
    end else begin
      qmag = qx[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NW; s++) begin
        r_q[s]   <= r_d[s];
        q_q[s]   <= q_d[s];
        n_q[s]   <= n_d[s];
        d_q[s]   <= d_d[s];
        neg_q[s] <= neg_d[s];
      end
      quo_q <= neg_q[NW-1] ? -$signed(qmag) : $signed(qmag);
    end
  end

  assign quo_o = quo_q;

endmodule

[src/d2q9_lane.sv]
module d2q9_lane #(
  parameter int POP_BITS  = d2q9_pkg::POP_BITS_DEF,
  parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [1:0]                dx_i,
  input  logic signed [1:0]                dy_i,
  input  d2q9_pkg::val_t                   w_i,
  input  logic [d2q9_pkg::RELAX_W-1:0]     omega_i,
  input  d2q9_pkg::val_t                   ux_i,
  input  d2q9_pkg::val_t                   uy_i,
  input  logic signed [POP_BITS+3:0]       rho_i,
  input  logic signed [POP_BITS-1:0]       f_i,
  input  d2q9_pkg::val_t                   usq_i,
  output logic signed [POP_BITS-1:0]       res_o,
  output logic signed [POP_BITS-1:0]       f_o
);

  localparam int L      = d2q9_pkg::MUL_LAT;
  localparam int VW     = d2q9_pkg::VAL_W;
  localparam int F_DLY  = d2q9_pkg::LANE_LAT;
  localparam int RW_DLY = L + 3;
  localparam int P1_DLY = L - 1;
  localparam logic signed [63:0] POP_MAX = (64'sd1 <<< (POP_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] POP_MIN = -(64'sd1 <<< (POP_BITS - 1));

  logic signed [POP_BITS-1:0] f_q [F_DLY];
  d2q9_pkg::val_t rw_q [RW_DLY];
  d2q9_pkg::val_t p1_q [P1_DLY];
  d2q9_pkg::val_t cu_q, poly1_q, poly2_q, poly3_q, m15_q, diff_q;
  logic signed [POP_BITS-1:0] res_q;

  d2q9_pkg::val_t m3, cu2, m45, m15, rhow, feq, mo;
  d2q9_pkg::val_t xs, ys;
  logic signed [63:0] sum;

  always_comb begin
    case (dx_i)
      2'sd1:   xs = ux_i;
      -2'sd1:  xs = -ux_i;
      default: xs = '0;
    endcase
    case (dy_i)
      2'sd1:   ys = uy_i;
      -2'sd1:  ys = -uy_i;
      default: ys = '0;
    endcase
    sum = 64'(f_q[3 + 4 * L]) + 64'(mo);
  end

  d2q9_mul #(.SH(FRAC_BITS)) u_m3 (
    .clk_i, .en_i, .a_i(d2q9_pkg::c_three(FRAC_BITS)), .b_i(cu_q), .p_o(m3)
  );
  d2q9_mul #(.SH(FRAC_BITS)) u_cu2 (
    .clk_i, .en_i, .a_i(cu_q), .b_i(cu_q), .p_o(cu2)
  );
  d2q9_mul #(.SH(FRAC_BITS)) u_m45 (
    .clk_i, .en_i, .a_i(d2q9_pkg::c_four_half(FRAC_BITS)), .b_i(cu2), .p_o(m45)
  );
  d2q9_mul #(.SH(FRAC_BITS)) u_m15 (
    .clk_i, .en_i, .a_i(d2q9_pkg::c_one_half(FRAC_BITS)), .b_i(usq_i), .p_o(m15)
  );
  d2q9_mul #(.SH(FRAC_BITS)) u_rhow (
    .clk_i, .en_i, .a_i(VW'(rho_i)), .b_i(w_i), .p_o(rhow)
  );
  d2q9_mul #(.SH(FRAC_BITS)) u_feq (
    .clk_i, .en_i, .a_i(rw_q[RW_DLY-1]), .b_i(poly3_q), .p_o(feq)
  );
  d2q9_mul #(.SH(d2q9_pkg::OMEGA_FRAC)) u_mo (
    .clk_i, .en_i, .a_i(VW'(omega_i)), .b_i(diff_q), .p_o(mo)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q[0] <= f_i;
      for (int k = 1; k < F_DLY; k++) f_q[k] <= f_q[k-1];
      rw_q[0] <= rhow;
      for (int k = 1; k < RW_DLY; k++) rw_q[k] <= rw_q[k-1];
      p1_q[0] <= poly1_q;
      for (int k = 1; k < P1_DLY; k++) p1_q[k] <= p1_q[k-1];
      cu_q    <= d2q9_pkg::sat_val(64'(xs) + 64'(ys));
      poly1_q <= d2q9_pkg::sat_val(64'(d2q9_pkg::c_one(FRAC_BITS)) + 64'(m3));
      poly2_q <= d2q9_pkg::sat_val(64'(p1_q[P1_DLY-1]) + 64'(m45));
      m15_q   <= m15;
      poly3_q <= d2q9_pkg::sat_val(64'(poly2_q) - 64'(m15_q));
      diff_q  <= d2q9_pkg::sat_val(64'(feq) - 64'(f_q[2 + 3 * L]));
      if (sum > POP_MAX) begin
        res_q <= POP_BITS'(POP_MAX);
      end else if (sum < POP_MIN) begin
        res_q <= POP_BITS'(POP_MIN);
      end else begin
        res_q <= POP_BITS'(sum);
      end
    end
  end

  assign res_o = res_q;
  assign f_o   = f_q[F_DLY-1];

endmodule

[src/d2q9_bgk_collision.sv]
// D2Q9 BGK collision, one lattice node per transfer.
// Input channel: in_valid_i/in_ready_o with the nine populations pop_in_*_i,
// signed with FRAC_BITS fraction bits. Output channel: out_valid_o/out_ready_i
// with pop_out_*_o and bad_density_o (density not positive, inputs passed
// through unchanged).
// Config: cfg_we_i writes omega (cfg_wdata_i, 28 fraction bits);
// write it only while the pipeline is empty.
// Pipeline depth: set by the radix-2 velocity divider, one quotient bit per
// stage, followed by the nine direction lanes built on four-stage multipliers
// and the output merge register.
// Throughput: one node per cycle while the receiver takes results.
// Stall: when the output register holds a result and out_ready_i is low, the
// whole pipeline holds and in_ready_o drops; nothing is lost.
// Reset: all valid flags clear, omega returns to 1.0.
module d2q9_bgk_collision #(
  parameter int POP_BITS  = d2q9_pkg::POP_BITS_DEF,
  parameter int FRAC_BITS = d2q9_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [d2q9_pkg::RELAX_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [POP_BITS-1:0]    pop_in_0_i,
  input  logic signed [POP_BITS-1:0]    pop_in_1_i,
  input  logic signed [POP_BITS-1:0]    pop_in_2_i,
  input  logic signed [POP_BITS-1:0]    pop_in_3_i,
  input  logic signed [POP_BITS-1:0]    pop_in_4_i,
  input  logic signed [POP_BITS-1:0]    pop_in_5_i,
  input  logic signed [POP_BITS-1:0]    pop_in_6_i,
  input  logic signed [POP_BITS-1:0]    pop_in_7_i,
  input  logic signed [POP_BITS-1:0]    pop_in_8_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [POP_BITS-1:0]    pop_out_0_o,
  output logic signed [POP_BITS-1:0]    pop_out_1_o,
  output logic signed [POP_BITS-1:0]    pop_out_2_o,
  output logic signed [POP_BITS-1:0]    pop_out_3_o,
  output logic signed [POP_BITS-1:0]    pop_out_4_o,
  output logic signed [POP_BITS-1:0]    pop_out_5_o,
  output logic signed [POP_BITS-1:0]    pop_out_6_o,
  output logic signed [POP_BITS-1:0]    pop_out_7_o,
  output logic signed [POP_BITS-1:0]    pop_out_8_o,
  output logic                          bad_density_o
);

  localparam int ND       = d2q9_pkg::NUM_DIR;
  localparam int RHO_W    = POP_BITS + 4;
  localparam int MOM_W    = POP_BITS + 3;
  localparam int DIV_LAT  = POP_BITS + FRAC_BITS + 3;
  localparam int LANE_LAT = d2q9_pkg::LANE_LAT;
  localparam int PIPE_D   = 2 + DIV_LAT + LANE_LAT;

  logic adv;
  logic [PIPE_D-1:0] vld_q;
  logic out_valid_q;
  logic [d2q9_pkg::RELAX_W-1:0] relax_q;

  logic signed [POP_BITS-1:0] f_in [ND];
  logic signed [POP_BITS-1:0] f_a_q [ND];
  logic signed [POP_BITS-1:0] f_b_q [ND];
  logic signed [RHO_W-1:0]    rho_b_q;
  logic signed [MOM_W-1:0]    mx_b_q, my_b_q;
  logic signed [RHO_W-1:0]    rho_d;
  logic signed [RHO_W-1:0]    mx_d, my_d;
  logic                       bad_b;

  logic signed [POP_BITS-1:0] fdv_q [DIV_LAT][ND];
  logic signed [RHO_W-1:0]    rdv_q [DIV_LAT];
  logic                       bdv_q [DIV_LAT];
  logic                       bln_q [LANE_LAT];

  d2q9_pkg::val_t ux, uy, uxx, uyy, usq_q;
  logic signed [POP_BITS-1:0] res [ND];
  logic signed [POP_BITS-1:0] fl  [ND];
  logic signed [POP_BITS-1:0] out_q [ND];
  logic                       bad_out_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  assign f_in[0] = pop_in_0_i;
  assign f_in[1] = pop_in_1_i;
  assign f_in[2] = pop_in_2_i;
  assign f_in[3] = pop_in_3_i;
  assign f_in[4] = pop_in_4_i;
  assign f_in[5] = pop_in_5_i;
  assign f_in[6] = pop_in_6_i;
  assign f_in[7] = pop_in_7_i;
  assign f_in[8] = pop_in_8_i;

  always_comb begin
    rho_d = '0;
    for (int i = 0; i < ND; i++) rho_d = rho_d + RHO_W'(f_a_q[i]);
    mx_d = RHO_W'(f_a_q[1]) + RHO_W'(f_a_q[5]) + RHO_W'(f_a_q[8])
         - (RHO_W'(f_a_q[3]) + RHO_W'(f_a_q[6]) + RHO_W'(f_a_q[7]));
    my_d = RHO_W'(f_a_q[2]) + RHO_W'(f_a_q[5]) + RHO_W'(f_a_q[6])
         - (RHO_W'(f_a_q[4]) + RHO_W'(f_a_q[7]) + RHO_W'(f_a_q[8]));
    bad_b = (rho_b_q <= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      relax_q     <= d2q9_pkg::RELAX_RST;
    end else begin
      if (cfg_we_i) begin
        relax_q <= cfg_wdata_i;
      end
      if (adv) begin
        vld_q       <= {vld_q[PIPE_D-2:0], in_valid_i};
        out_valid_q <= vld_q[PIPE_D-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_a_q   <= f_in;
      f_b_q   <= f_a_q;
      rho_b_q <= rho_d;
      mx_b_q  <= MOM_W'(mx_d);
      my_b_q  <= MOM_W'(my_d);
      fdv_q[0] <= f_b_q;
      rdv_q[0] <= rho_b_q;
      bdv_q[0] <= bad_b;
      for (int k = 1; k < DIV_LAT; k++) begin
        fdv_q[k] <= fdv_q[k-1];
        rdv_q[k] <= rdv_q[k-1];
        bdv_q[k] <= bdv_q[k-1];
      end
      bln_q[0] <= bdv_q[DIV_LAT-1];
      for (int k = 1; k < LANE_LAT; k++) bln_q[k] <= bln_q[k-1];
      usq_q <= d2q9_pkg::sat_val(64'(uxx) + 64'(uyy));
      for (int i = 0; i < ND; i++) begin
        out_q[i] <= bln_q[LANE_LAT-1] ? fl[i] : res[i];
      end
      bad_out_q <= bln_q[LANE_LAT-1];
    end
  end

  d2q9_div #(.POP_BITS(POP_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i, .en_i(adv), .num_i(mx_b_q), .den_i(rho_b_q), .quo_o(ux)
  );
  d2q9_div #(.POP_BITS(POP_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i, .en_i(adv), .num_i(my_b_q), .den_i(rho_b_q), .quo_o(uy)
  );

  d2q9_mul #(.SH(FRAC_BITS)) u_uxx (
    .clk_i, .en_i(adv), .a_i(ux), .b_i(ux), .p_o(uxx)
  );
  d2q9_mul #(.SH(FRAC_BITS)) u_uyy (
    .clk_i, .en_i(adv), .a_i(uy), .b_i(uy), .p_o(uyy)
  );

  for (genvar g = 0; g < ND; g++) begin : g_lane
    d2q9_lane #(.POP_BITS(POP_BITS), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i,
      .en_i    (adv),
      .dx_i    (d2q9_pkg::dir_x(g)),
      .dy_i    (d2q9_pkg::dir_y(g)),
      .w_i     (d2q9_pkg::weight(g, FRAC_BITS)),
      .omega_i (relax_q),
      .ux_i    (ux),
      .uy_i    (uy),
      .rho_i   (rdv_q[DIV_LAT-1]),
      .f_i     (fdv_q[DIV_LAT-1][g]),
      .usq_i   (usq_q),
      .res_o   (res[g]),
      .f_o     (fl[g])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign bad_density_o = bad_out_q;
  assign pop_out_0_o   = out_q[0];
  assign pop_out_1_o   = out_q[1];
  assign pop_out_2_o   = out_q[2];
  assign pop_out_3_o   = out_q[3];
  assign pop_out_4_o   = out_q[4];
  assign pop_out_5_o   = out_q[5];
  assign pop_out_6_o   = out_q[6];
  assign pop_out_7_o   = out_q[7];
  assign pop_out_8_o   = out_q[8];

endmodule

[src/d2q9_chk.sv]
`include "assert_macros.svh"

module d2q9_chk #(
  parameter int POP_BITS = d2q9_pkg::POP_BITS_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [POP_BITS-1:0] pop_out_0_i,
  input logic                       bad_density_i
);

  `AST_CHK_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !out_valid_i, "output valid after reset")
  `AST_CHK(a_stall_only, clk_i, rst_ni, !in_ready_i |-> (out_valid_i && !out_ready_i), "input stalled without output stall")
  `AST_CHK(a_ready_free, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "input stalled with empty output")
  `AST_CHK(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(pop_out_0_i) && $stable(bad_density_i)), "stalled result changed")

endmodule

bind d2q9_bgk_collision d2q9_chk #(.POP_BITS(POP_BITS)) u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_ready_o),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pop_out_0_i   (pop_out_0_o),
  .bad_density_i (bad_density_o)
);

[dv/d2q9_bgk_collision_tb.sv]
`timescale 1ns / 100ps

module d2q9_bgk_collision_tb;

  localparam int PB = 32;
  localparam int FB = 28;
  localparam int PIPE_LAT = PB + FB + 26;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_LEN = 300;
  localparam longint SAT_Q = 64'sd1 <<< 60;

  typedef logic [d2q9_pkg::NUM_DIR-1:0][PB-1:0] node_t;
  typedef struct packed {
    node_t pop;
    logic  bad;
  } node_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [d2q9_pkg::RELAX_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  node_t pop_drv = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  node_t pop_mon;
  logic bad_density_o;

  node_res_t post_q[$];
  logic [d2q9_pkg::RELAX_W-1:0] omega_q = d2q9_pkg::RELAX_RST;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_bad = 0;
  int n_cfg = 0;
  int quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  d2q9_bgk_collision DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .pop_in_0_i(pop_drv[0]), .pop_in_1_i(pop_drv[1]), .pop_in_2_i(pop_drv[2]),
    .pop_in_3_i(pop_drv[3]), .pop_in_4_i(pop_drv[4]), .pop_in_5_i(pop_drv[5]),
    .pop_in_6_i(pop_drv[6]), .pop_in_7_i(pop_drv[7]), .pop_in_8_i(pop_drv[8]),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pop_out_0_o(pop_mon[0]), .pop_out_1_o(pop_mon[1]), .pop_out_2_o(pop_mon[2]),
    .pop_out_3_o(pop_mon[3]), .pop_out_4_o(pop_mon[4]), .pop_out_5_o(pop_mon[5]),
    .pop_out_6_o(pop_mon[6]), .pop_out_7_o(pop_mon[7]), .pop_out_8_o(pop_mon[8]),
    .bad_density_o(bad_density_o)
  );

  function automatic longint sat_q(input longint v);
    return v > SAT_Q ? SAT_Q : (v < -SAT_Q ? -SAT_Q : v);
  endfunction

  function automatic longint mul_q(input longint a, input longint b, input int sh);
    logic [127:0] ma, mb, pr;
    longint m;
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    pr = (ma * mb + (128'd1 << (sh - 1))) >> sh;
    m = pr > 128'(SAT_Q) ? SAT_Q : longint'(pr[63:0]);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint div_q(input longint num, input longint den);
    logic [127:0] n, q;
    longint m;
    n = num < 0 ? 128'(-num) : 128'(num);
    q = (n << FB) / 128'(den);
    m = q > 128'(SAT_Q) ? SAT_Q : longint'(q[63:0]);
    return num < 0 ? -m : m;
  endfunction

  function automatic node_res_t collide(input node_t p,
                                        input logic [d2q9_pkg::RELAX_W-1:0] om);
    node_res_t r;
    longint f[d2q9_pkg::NUM_DIR];
    longint cx[d2q9_pkg::NUM_DIR], cy[d2q9_pkg::NUM_DIR];
    longint rho, mx, my, ux, uy, usq, w, cu, poly, feq, diff, res;
    cx = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    cy = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    rho = 0;
    for (int i = 0; i < d2q9_pkg::NUM_DIR; i++) begin
      f[i] = longint'(signed'(p[i]));
      rho += f[i];
    end
    r.pop = p;
    r.bad = 1'b1;
    if (rho > 0) begin
      r.bad = 1'b0;
      mx = f[1] + f[5] + f[8] - (f[3] + f[6] + f[7]);
      my = f[2] + f[5] + f[6] - (f[4] + f[7] + f[8]);
      ux = div_q(mx, rho);
      uy = div_q(my, rho);
      usq = sat_q(mul_q(ux, ux, FB) + mul_q(uy, uy, FB));
      for (int i = 0; i < d2q9_pkg::NUM_DIR; i++) begin
        if (i == 0) w = ((64'sd8 <<< FB) + 9) / 18;
        else if (i < 5) w = ((64'sd2 <<< FB) + 9) / 18;
        else w = ((64'sd2 <<< FB) + 36) / 72;
        cu = sat_q(cx[i] * ux + cy[i] * uy);
        poly = sat_q((64'sd1 <<< FB) + mul_q(64'sd3 <<< FB, cu, FB));
        poly = sat_q(poly + mul_q(64'sd9 <<< (FB - 1), mul_q(cu, cu, FB), FB));
        poly = sat_q(poly - mul_q(64'sd3 <<< (FB - 1), usq, FB));
        feq = mul_q(mul_q(rho, w, FB), poly, FB);
        diff = sat_q(feq - f[i]);
        res = f[i] + mul_q(longint'(om), diff, d2q9_pkg::OMEGA_FRAC);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        r.pop[i] = res[PB-1:0];
      end
    end
    return r;
  endfunction

  // receiver: hold-off countdown, else random stall
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result checker and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin
    node_res_t got, want;
    if (rst_ni && ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)))
      quiet_cycles = 0;
    else if (rst_ni)
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, post_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.pop = pop_mon;
      got.bad = bad_density_o;
      n_recv++;
      if (post_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %0d", n_recv);
      end else begin
        want = post_q.pop_front();
        if (got.bad) n_bad++;
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at result %0d: bad exp %0b got %0b", n_recv, want.bad, got.bad);
            for (int i = 0; i < d2q9_pkg::NUM_DIR; i++)
              if (got.pop[i] !== want.pop[i])
                $display("  pop[%0d] exp %0d got %0d", i, signed'(want.pop[i]),
                         signed'(got.pop[i]));
          end
        end
      end
    end
  end

  task automatic send_node(input node_t p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pop_drv <= p;
    do @(negedge clk_i); while (!in_ready_o);
    post_q.push_back(collide(p, omega_q));
    n_sent++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (post_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  task automatic set_omega(input logic [d2q9_pkg::RELAX_W-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    omega_q = v;
    n_cfg++;
  endtask

  function automatic node_t rand_node();
    node_t p;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < d2q9_pkg::NUM_DIR; i++) begin
      case (kind)
        7: p[i] = $urandom;
        8: p[i] = -$urandom_range(0, 30000000);
        9: p[i] = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        default: p[i] = $urandom_range(1000000, 60000000) >> $urandom_range(0, 3);
      endcase
    end
    if (kind == 6) p[$urandom_range(1, 8)] = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h1;
    return p;
  endfunction

  task automatic test_directed();
    node_t p;
    p = '0; send_node(p);
    p = {d2q9_pkg::NUM_DIR{32'h7fff_ffff}}; send_node(p);
    p = {d2q9_pkg::NUM_DIR{32'h8000_0000}}; send_node(p);
    p = {d2q9_pkg::NUM_DIR{32'hffff_ffff}}; send_node(p);
    p = '0; p[0] = 32'h7fff_ffff; send_node(p);
    p = '0; p[0] = 32'd1; send_node(p);
    p = {d2q9_pkg::NUM_DIR{32'd29826162}}; send_node(p);
    for (int d = 1; d < d2q9_pkg::NUM_DIR; d++) begin
      p = '0; p[d] = 32'h7fff_ffff; p[0] = 32'h8000_0002; send_node(p);
    end
    p = {d2q9_pkg::NUM_DIR{32'h7fff_ffff}}; p[0] = 32'h8000_0000; send_node(p);
    p = '0; p[1] = 32'h7fff_ffff; p[3] = 32'h8000_0001; send_node(p);
    p = '0; p[5] = 32'h1000_0000; p[7] = 32'hf000_0001; send_node(p);
    p = {d2q9_pkg::NUM_DIR{32'h5555_5555}}; send_node(p);
    p = {d2q9_pkg::NUM_DIR{32'h2aaa_aaaa}}; send_node(p);
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < n; k++) send_node(rand_node());
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_req = HOLD_LEN;
    for (int k = 0; k < 120; k++) send_node(rand_node());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_omega('0);
    test_directed();
    set_omega(30'h2000_0000);
    test_random(110, 0, 0);
    set_omega(30'h3fff_ffff);
    test_random(110, 50, 0);
    set_omega(30'($urandom_range(0, 30'h2000_0000)));
    test_random(110, 0, 50);
    set_omega(d2q9_pkg::RELAX_RST);
    test_random(110, 21, 21);
    set_omega(30'h0c00_0000);
    test_backpressure();
    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d nodes (%0d with non-positive density), %0d omega writes,",
             n_sent, n_bad, n_cfg);
    $display("idle and stall phases plus a %0d-cycle output hold; %0d errors",
             HOLD_LEN, errors);
    if (errors == 0 && post_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/d2q9_pkg.sv
src/d2q9_mul.sv
src/d2q9_div.sv
src/d2q9_lane.sv
src/d2q9_bgk_collision.sv
src/d2q9_chk.sv
dv/d2q9_bgk_collision_tb.sv
